FILE: hdl/mdhfk_pkg.sv
`timescale 1ns / 1ps

package mdhfk_pkg;

	// Fixed-point formats
	localparam int ANGLE_FRAC_BITS  = 13;
	localparam int LENGTH_FRAC_BITS = 16;
	localparam int ROT_FRAC_BITS    = 14;
	localparam int POS_GUARD        = 8;

	localparam int ANGLE_W = 16;
	localparam int LEN_W   = 18;
	localparam int ROT_W   = 16;
	localparam int POS_W   = 20;
	localparam int TRIG_W  = 32;  // Q30 sin, cos and running rotation
	localparam int RUN_W   = 32;  // running position, Q(LENGTH_FRAC_BITS + POS_GUARD)

	localparam int NUM_JOINTS = 6;

	typedef logic signed [ANGLE_W-1:0] angle_t;
	typedef logic signed [LEN_W-1:0]   len_t;
	typedef logic signed [TRIG_W-1:0]  trig_t;
	typedef logic signed [RUN_W-1:0]   run_t;
	typedef logic signed [ROT_W-1:0]   rot_t;
	typedef logic signed [POS_W-1:0]   pos_t;

	localparam trig_t ONE_Q30 = 32'sh4000_0000;

	// Angle constants in Q30
	localparam longint PI_Q30      = 64'sd3373259426;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint TWO_PI_Q30  = 64'sd6746518852;

	// Width of the angle while it is wrapped, and how many 2*pi steps it can need
	localparam int XR_W = (48 - ANGLE_FRAC_BITS > 36) ? 48 - ANGLE_FRAC_BITS : 36;
	localparam int ANGLE_WRAPS =
		int'(((64'sd1 <<< (45 - ANGLE_FRAC_BITS)) / TWO_PI_Q30) + 64'sd1);

	// Taylor series divisors, Horner order
	localparam int SIN_STEPS = 6;
	localparam int COS_STEPS = 7;
	localparam int SIN_DIV [SIN_STEPS] = '{156, 110, 72, 42, 20, 6};
	localparam int COS_DIV [COS_STEPS] = '{182, 132, 90, 56, 30, 12, 2};

	// Pipeline depths
	localparam int HORNER_LAT = 4;
	localparam int TRIG_LAT   = HORNER_LAT * COS_STEPS + 4;
	localparam int LINK_LAT   = 2;

	// Link that consumes each joint angle
	localparam int JOINT_LINK [NUM_JOINTS] = '{0, 1, 2, 3, 5, 7};

	// Round micrometres to Q.LENGTH_FRAC_BITS metres, ties away from zero
	function automatic longint micro_to_len(input longint um);
		longint mag;
		longint r;
		mag = (um < 0) ? -um : um;
		r = (mag * (64'sd1 <<< LENGTH_FRAC_BITS) + 64'sd500000) / 64'sd1000000;
		return (um < 0) ? -r : r;
	endfunction

	localparam len_t D3_LEN = len_t'(micro_to_len(64'sd19450));
	localparam len_t D4_LEN = len_t'(micro_to_len(-64'sd6610));
	localparam len_t D5_LEN = len_t'(micro_to_len(64'sd58400));

	// Configuration registers
	typedef enum logic [2:0] {
		CFG_BASE_HEIGHT     = 3'd0,
		CFG_SHOULDER_OFFSET = 3'd1,
		CFG_WRIST_OFFSET    = 3'd2,
		CFG_TOOL_OFFSET     = 3'd3,
		CFG_UPPER_ARM       = 3'd4,
		CFG_FOREARM         = 3'd5,
		CFG_WRIST_ONE       = 3'd6,
		CFG_WRIST_TWO       = 3'd7
	} cfg_reg_t;

	localparam len_t RST_BASE_HEIGHT     = 18'sd7143;
	localparam len_t RST_SHOULDER_OFFSET = 18'sd6634;
	localparam len_t RST_WRIST_OFFSET    = 18'sd6142;
	localparam len_t RST_TOOL_OFFSET     = 18'sd6463;
	localparam len_t RST_UPPER_ARM       = 18'sd40115;
	localparam len_t RST_FOREARM         = 18'sd37500;
	localparam len_t RST_WRIST_ONE       = 18'sd3755;
	localparam len_t RST_WRIST_TWO       = 18'sd3827;

endpackage

FILE: hdl/mdhfk_delay.sv
`timescale 1ns / 1ps

module mdhfk_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] line_q [DEPTH];

	// Shift one place per advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) line_q[i] <= '0;
		end else if (en) begin
			line_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) line_q[i] <= line_q[i-1];
		end
	end

	assign q = line_q[DEPTH-1];

endmodule

FILE: hdl/mdhfk_horner.sv
`timescale 1ns / 1ps

module mdhfk_horner import mdhfk_pkg::*; #(
	parameter int K = 2
) (
	input  logic        clk,
	input  logic        en,
	input  trig_t       t_in,
	input  logic [31:0] x2_in,
	output trig_t       t_out,
	output logic [31:0] x2_out
);

	// Reciprocal of K in Q32; the quotient it gives is at most one short
	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / K);
	localparam logic [39:0] KV    = 40'(K);

	logic [62:0] prod_s1;
	logic [31:0] x2_s1, x2_s2, x2_s3, x2_s4;
	logic [31:0] v_s2, v_s3, q0_s3;
	trig_t       t_s4;

	logic [62:0] rsum;
	logic [63:0] qprod;
	logic [39:0] rem;
	logic [31:0] quo;

	always_comb begin
		rsum  = prod_s1 + (63'd1 << 29);
		qprod = 64'(v_s2) * 64'(RECIP);
		rem   = 40'(v_s3) - 40'(q0_s3) * KV;
		quo   = (rem >= KV) ? q0_s3 + 32'd1 : q0_s3;
	end

	// Multiply, round, estimate quotient, correct and subtract from one
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= 63'(t_in[30:0]) * 63'(x2_in);
			x2_s1   <= x2_in;
			v_s2    <= rsum[61:30];
			x2_s2   <= x2_s1;
			q0_s3   <= qprod[63:32];
			v_s3    <= v_s2;
			x2_s3   <= x2_s2;
			t_s4    <= ONE_Q30 - quo;
			x2_s4   <= x2_s3;
		end
	end

	assign t_out  = t_s4;
	assign x2_out = x2_s4;

endmodule

FILE: hdl/mdhfk_trig.sv
`timescale 1ns / 1ps

module mdhfk_trig import mdhfk_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   v_in,
	input  angle_t angle [NUM_JOINTS],
	output logic   v_out,
	output trig_t  cos_v [NUM_JOINTS],
	output trig_t  sin_v [NUM_JOINTS]
);

	localparam logic signed [XR_W-1:0] PI_X      = XR_W'(PI_Q30);
	localparam logic signed [XR_W-1:0] HALF_PI_X = XR_W'(HALF_PI_Q30);
	localparam logic signed [XR_W-1:0] TWO_PI_X  = XR_W'(TWO_PI_Q30);
	localparam int SIN_X_DLY  = HORNER_LAT * SIN_STEPS + 2;
	localparam int NEG_DLY    = HORNER_LAT * COS_STEPS + 2;
	localparam int SIN_OUT_DLY = TRIG_LAT - (HORNER_LAT * SIN_STEPS + 5);

	// Valid travels beside the lanes
	mdhfk_delay #(.WIDTH(1), .DEPTH(TRIG_LAT)) u_vld (
		.clk(clk), .arst_n(arst_n), .en(en), .d(v_in), .q(v_out)
	);

	for (genvar g = 0; g < NUM_JOINTS; g++) begin : g_lane
		logic signed [XR_W-1:0] xr;
		logic                   neg_c;
		trig_t                  x_s1;
		logic                   neg_s1;
		logic signed [63:0]     sq_s2;
		logic [31:0]            x2_s3;
		trig_t                  ct_w [COS_STEPS+1];
		logic [31:0]            cx_w [COS_STEPS+1];
		trig_t                  st_w [SIN_STEPS+1];
		logic [31:0]            sx_w [SIN_STEPS+1];
		logic [31:0]            x_d;
		logic                   neg_d;
		logic signed [63:0]     sp_s28;
		trig_t                  sn_s29;
		logic [31:0]            sn_d;
		trig_t                  cos_s32;

		// Wrap into [-pi, pi], then fold into [-pi/2, pi/2]
		always_comb begin
			xr = XR_W'(angle[g]) <<< (30 - ANGLE_FRAC_BITS);
			for (int w = 0; w < ANGLE_WRAPS; w++) begin
				if (xr > PI_X) xr = xr - TWO_PI_X;
				else if (xr < -PI_X) xr = xr + TWO_PI_X;
			end
			neg_c = 1'b0;
			if (xr > HALF_PI_X) begin
				xr    = PI_X - xr;
				neg_c = 1'b1;
			end else if (xr < -HALF_PI_X) begin
				xr    = -PI_X - xr;
				neg_c = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s1    <= trig_t'(xr);
				neg_s1  <= neg_c;
				sq_s2   <= x_s1 * x_s1;
				x2_s3   <= 32'((sq_s2 + 64'sd536870912) >>> 30);
				sp_s28  <= $signed(x_d) * st_w[SIN_STEPS];
				sn_s29  <= trig_t'((sp_s28 + 64'sd536870912) >>> 30);
				cos_s32 <= neg_d ? -ct_w[COS_STEPS] : ct_w[COS_STEPS];
			end
		end

		// Cosine series
		assign ct_w[0] = ONE_Q30;
		assign cx_w[0] = x2_s3;
		for (genvar k = 0; k < COS_STEPS; k++) begin : g_cos
			mdhfk_horner #(.K(COS_DIV[k])) u_step (
				.clk(clk), .en(en), .t_in(ct_w[k]), .x2_in(cx_w[k]),
				.t_out(ct_w[k+1]), .x2_out(cx_w[k+1])
			);
		end

		// Sine series
		assign st_w[0] = ONE_Q30;
		assign sx_w[0] = x2_s3;
		for (genvar k = 0; k < SIN_STEPS; k++) begin : g_sin
			mdhfk_horner #(.K(SIN_DIV[k])) u_step (
				.clk(clk), .en(en), .t_in(st_w[k]), .x2_in(sx_w[k]),
				.t_out(st_w[k+1]), .x2_out(sx_w[k+1])
			);
		end

		mdhfk_delay #(.WIDTH(32), .DEPTH(SIN_X_DLY)) u_xdly (
			.clk(clk), .arst_n(arst_n), .en(en), .d(x_s1), .q(x_d)
		);
		mdhfk_delay #(.WIDTH(1), .DEPTH(NEG_DLY)) u_ndly (
			.clk(clk), .arst_n(arst_n), .en(en), .d(neg_s1), .q(neg_d)
		);
		mdhfk_delay #(.WIDTH(32), .DEPTH(SIN_OUT_DLY)) u_sdly (
			.clk(clk), .arst_n(arst_n), .en(en), .d(sn_s29), .q(sn_d)
		);

		assign cos_v[g] = cos_s32;
		assign sin_v[g] = $signed(sn_d);
	end

endmodule

FILE: hdl/mdhfk_link.sv
`timescale 1ns / 1ps

module mdhfk_link import mdhfk_pkg::*; #(
	parameter int SA = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  v_in,
	input  trig_t r_in [3][3],
	input  run_t  p_in [3],
	input  trig_t ct,
	input  trig_t st,
	input  len_t  a,
	input  len_t  d,
	output logic  v_out,
	output trig_t r_out [3][3],
	output run_t  p_out [3]
);

	localparam int PSH = 30 - POS_GUARD;

	trig_t              ra [3][3];
	logic signed [18:0] pa [3];

	logic signed [63:0] rm_s1 [3][3][3];
	logic signed [50:0] pm_s1 [3][3];
	run_t               p_s1  [3];
	logic               v_s1;
	trig_t              r_s2  [3][3];
	run_t               p_s2  [3];
	logic               v_s2;

	// Build the link rotation and translation
	always_comb begin
		ra[0][0] = ct;
		ra[0][1] = -st;
		ra[0][2] = '0;
		pa[0]    = 19'(a);
		if (SA == 0) begin
			ra[1][0] = st;  ra[1][1] = ct;  ra[1][2] = '0;
			ra[2][0] = '0;  ra[2][1] = '0;  ra[2][2] = ONE_Q30;
			pa[1] = '0;
			pa[2] = 19'(d);
		end else if (SA > 0) begin
			ra[1][0] = '0;  ra[1][1] = '0;  ra[1][2] = -ONE_Q30;
			ra[2][0] = st;  ra[2][1] = ct;  ra[2][2] = '0;
			pa[1] = -19'(d);
			pa[2] = '0;
		end else begin
			ra[1][0] = '0;  ra[1][1] = '0;  ra[1][2] = ONE_Q30;
			ra[2][0] = -st; ra[2][1] = -ct; ra[2][2] = '0;
			pa[1] = 19'(d);
			pa[2] = '0;
		end
	end

	// Stage 1: all products against the running rotation
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				p_s1[i] <= p_in[i];
				for (int k = 0; k < 3; k++) begin
					pm_s1[i][k] <= r_in[i][k] * pa[k];
					for (int j = 0; j < 3; j++) rm_s1[i][j][k] <= r_in[i][k] * ra[k][j];
				end
			end
		end
	end

	// Stage 2: sum and round
	always_ff @(posedge clk) begin
		logic signed [65:0] rs;
		logic signed [52:0] ps;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ps = 53'(pm_s1[i][0]) + 53'(pm_s1[i][1]) + 53'(pm_s1[i][2]);
				p_s2[i] <= p_s1[i] + run_t'((ps + (53'sd1 <<< (PSH - 1))) >>> PSH);
				for (int j = 0; j < 3; j++) begin
					rs = 66'(rm_s1[i][j][0]) + 66'(rm_s1[i][j][1]) + 66'(rm_s1[i][j][2]);
					r_s2[i][j] <= trig_t'((rs + 66'sd536870912) >>> 30);
				end
			end
		end
	end

	// Valid follows the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
		end
	end

	assign v_out = v_s2;
	assign r_out = r_s2;
	assign p_out = p_s2;

endmodule

FILE: hdl/mdh_forward_kinematics_top.sv
`timescale 1ns / 1ps

// Channel   Handshake              Beat contents
// in        in_valid / in_ready    joint_angle_1 .. joint_angle_6, Q2.13 rad
// out       out_valid / out_ready  rot_00 .. rot_22 Q1.14, pos_x/y/z Q.16 m
// cfg       cfg_we                 cfg_index, cfg_data (link lengths, Q.16 m)
//
// One beat enters per cycle unless the pipeline holds. The sine/cosine series
// runs one Horner step per four stages, then nine links and the output register.
// When an output beat is not taken the whole pipeline holds in place.
// Reset clears all valid bits and loads the default link lengths.

module mdh_forward_kinematics_top import mdhfk_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  angle_t       joint_angle_1,
	input  angle_t       joint_angle_2,
	input  angle_t       joint_angle_3,
	input  angle_t       joint_angle_4,
	input  angle_t       joint_angle_5,
	input  angle_t       joint_angle_6,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [17:0]  cfg_data,
	output logic         out_valid,
	input  logic         out_ready,
	output rot_t         rot_00,
	output rot_t         rot_01,
	output rot_t         rot_02,
	output rot_t         rot_10,
	output rot_t         rot_11,
	output rot_t         rot_12,
	output rot_t         rot_20,
	output rot_t         rot_21,
	output rot_t         rot_22,
	output pos_t         pos_x,
	output pos_t         pos_y,
	output pos_t         pos_z
);

	localparam int RSH = 30 - ROT_FRAC_BITS;
	localparam logic signed [32:0] ROT_ONE = 33'sd1 <<< ROT_FRAC_BITS;
	localparam logic signed [32:0] POS_MAX = 33'sd524287;
	localparam logic signed [32:0] POS_MIN = -33'sd524288;

	len_t base_height_q, shoulder_offset_q, wrist_offset_q, tool_offset_q;
	len_t upper_arm_q, forearm_q, wrist_one_q, wrist_two_q;

	logic   en;
	angle_t ang [NUM_JOINTS];
	logic   trig_v;
	trig_t  cos_w [NUM_JOINTS];
	trig_t  sin_w [NUM_JOINTS];
	trig_t  c_d [NUM_JOINTS];
	trig_t  s_d [NUM_JOINTS];
	trig_t  nc1;

	trig_t  r_c [10][3][3];
	run_t   p_c [10][3];
	logic   v_c [10];

	logic   out_valid_q;
	rot_t   rot_q [3][3];
	pos_t   pos_q [3];
	rot_t   rot_n [3][3];
	pos_t   pos_n [3];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_height_q     <= RST_BASE_HEIGHT;
			shoulder_offset_q <= RST_SHOULDER_OFFSET;
			wrist_offset_q    <= RST_WRIST_OFFSET;
			tool_offset_q     <= RST_TOOL_OFFSET;
			upper_arm_q       <= RST_UPPER_ARM;
			forearm_q         <= RST_FOREARM;
			wrist_one_q       <= RST_WRIST_ONE;
			wrist_two_q       <= RST_WRIST_TWO;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_BASE_HEIGHT:     base_height_q     <= $signed(cfg_data);
				CFG_SHOULDER_OFFSET: shoulder_offset_q <= $signed(cfg_data);
				CFG_WRIST_OFFSET:    wrist_offset_q    <= $signed(cfg_data);
				CFG_TOOL_OFFSET:     tool_offset_q     <= $signed(cfg_data);
				CFG_UPPER_ARM:       upper_arm_q       <= $signed(cfg_data);
				CFG_FOREARM:         forearm_q         <= $signed(cfg_data);
				CFG_WRIST_ONE:       wrist_one_q       <= $signed(cfg_data);
				CFG_WRIST_TWO:       wrist_two_q       <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// Advance whenever the output slot is free or being emptied
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	assign ang[0] = joint_angle_1;
	assign ang[1] = joint_angle_2;
	assign ang[2] = joint_angle_3;
	assign ang[3] = joint_angle_4;
	assign ang[4] = joint_angle_5;
	assign ang[5] = joint_angle_6;

	mdhfk_trig u_trig (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(in_valid && in_ready),
		.angle(ang), .v_out(trig_v), .cos_v(cos_w), .sin_v(sin_w)
	);

	// Hold each joint's sin/cos until its link comes up
	for (genvar g = 0; g < NUM_JOINTS; g++) begin : g_jdly
		if (JOINT_LINK[g] == 0) begin : g_direct
			assign c_d[g] = cos_w[g];
			assign s_d[g] = sin_w[g];
		end else begin : g_delay
			logic [63:0] cs_q;
			mdhfk_delay #(.WIDTH(64), .DEPTH(LINK_LAT * JOINT_LINK[g])) u_dly (
				.clk(clk), .arst_n(arst_n), .en(en),
				.d({cos_w[g], sin_w[g]}), .q(cs_q)
			);
			assign c_d[g] = $signed(cs_q[63:32]);
			assign s_d[g] = $signed(cs_q[31:0]);
		end
	end

	assign nc1 = -c_d[1];

	// Chain starts at the identity
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			p_c[0][i] = '0;
			for (int j = 0; j < 3; j++) r_c[0][i][j] = (i == j) ? ONE_Q30 : '0;
		end
	end
	assign v_c[0] = trig_v;

	mdhfk_link #(.SA(0)) u_link0 (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_c[0]), .r_in(r_c[0]), .p_in(p_c[0]),
		.ct(c_d[0]), .st(s_d[0]), .a('0), .d(base_height_q),
		.v_out(v_c[1]), .r_out(r_c[1]), .p_out(p_c[1])
	);
	mdhfk_link #(.SA(-1)) u_link1 (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_c[1]), .r_in(r_c[1]), .p_in(p_c[1]),
		.ct(s_d[1]), .st(nc1), .a('0), .d(shoulder_offset_q),
		.v_out(v_c[2]), .r_out(r_c[2]), .p_out(p_c[2])
	);
	mdhfk_link #(.SA(0)) u_link2 (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_c[2]), .r_in(r_c[2]), .p_in(p_c[2]),
		.ct(c_d[2]), .st(s_d[2]), .a(upper_arm_q), .d(D3_LEN),
		.v_out(v_c[3]), .r_out(r_c[3]), .p_out(p_c[3])
	);
	mdhfk_link #(.SA(0)) u_link3 (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_c[3]), .r_in(r_c[3]), .p_in(p_c[3]),
		.ct(c_d[3]), .st(s_d[3]), .a(forearm_q), .d(D4_LEN),
		.v_out(v_c[4]), .r_out(r_c[4]), .p_out(p_c[4])
	);
	mdhfk_link #(.SA(0)) u_link4 (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_c[4]), .r_in(r_c[4]), .p_in(p_c[4]),
		.ct('0), .st(ONE_Q30), .a(wrist_one_q), .d(D5_LEN),
		.v_out(v_c[5]), .r_out(r_c[5]), .p_out(p_c[5])
	);
	mdhfk_link #(.SA(1)) u_link5 (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_c[5]), .r_in(r_c[5]), .p_in(p_c[5]),
		.ct(c_d[4]), .st(s_d[4]), .a('0), .d('0),
		.v_out(v_c[6]), .r_out(r_c[6]), .p_out(p_c[6])
	);
	mdhfk_link #(.SA(-1)) u_link6 (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_c[6]), .r_in(r_c[6]), .p_in(p_c[6]),
		.ct('0), .st(-ONE_Q30), .a('0), .d('0),
		.v_out(v_c[7]), .r_out(r_c[7]), .p_out(p_c[7])
	);
	mdhfk_link #(.SA(0)) u_link7 (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_c[7]), .r_in(r_c[7]), .p_in(p_c[7]),
		.ct(c_d[5]), .st(s_d[5]), .a(wrist_two_q), .d(wrist_offset_q),
		.v_out(v_c[8]), .r_out(r_c[8]), .p_out(p_c[8])
	);
	mdhfk_link #(.SA(0)) u_link8 (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_c[8]), .r_in(r_c[8]), .p_in(p_c[8]),
		.ct(ONE_Q30), .st('0), .a('0), .d(tool_offset_q),
		.v_out(v_c[9]), .r_out(r_c[9]), .p_out(p_c[9])
	);

	// Round and saturate the final pose
	always_comb begin
		logic signed [32:0] rw;
		logic signed [32:0] pw;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				rw = (33'(r_c[9][i][j]) + (33'sd1 <<< (RSH - 1))) >>> RSH;
				if (rw > ROT_ONE) rw = ROT_ONE;
				else if (rw < -ROT_ONE) rw = -ROT_ONE;
				rot_n[i][j] = rot_t'(rw);
			end
			pw = (33'(p_c[9][i]) + (33'sd1 <<< (POS_GUARD - 1))) >>> POS_GUARD;
			if (pw > POS_MAX) pw = POS_MAX;
			else if (pw < POS_MIN) pw = POS_MIN;
			pos_n[i] = pos_t'(pw);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_q <= rot_n;
			pos_q <= pos_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= v_c[9];
	end

	assign out_valid = out_valid_q;
	assign rot_00 = rot_q[0][0];
	assign rot_01 = rot_q[0][1];
	assign rot_02 = rot_q[0][2];
	assign rot_10 = rot_q[1][0];
	assign rot_11 = rot_q[1][1];
	assign rot_12 = rot_q[1][2];
	assign rot_20 = rot_q[2][0];
	assign rot_21 = rot_q[2][1];
	assign rot_22 = rot_q[2][2];
	assign pos_x  = pos_q[0];
	assign pos_y  = pos_q[1];
	assign pos_z  = pos_q[2];

endmodule

FILE: sim/tb_mdh_forward_kinematics_top.sv
`timescale 1ns / 1ps

module tb_mdh_forward_kinematics_top;
	import mdhfk_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 70;

	typedef struct {
		angle_t ang [NUM_JOINTS];
	} joints_t;

	typedef struct {
		rot_t rot [9];
		pos_t pos [3];
	} pose_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	angle_t joint_angle_1 = '0;
	angle_t joint_angle_2 = '0;
	angle_t joint_angle_3 = '0;
	angle_t joint_angle_4 = '0;
	angle_t joint_angle_5 = '0;
	angle_t joint_angle_6 = '0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [17:0] cfg_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rot_t rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22;
	pos_t pos_x, pos_y, pos_z;

	mdh_forward_kinematics_top dut (.*);

	joints_t joint_queue [$];
	pose_t pose_queue [$];
	longint link_len [8];
	longint arm_rot [3][3];
	longint arm_pos [3];
	int send_idle_pct = 15;
	int recv_idle_pct = 78;
	int errors = 0;
	int poses_seen = 0;
	int hold_cycles = 0;
	bit hold_done = 1'b0;
	int cycle_cnt = 0;

	always #10 clk = ~clk;

	// Round half up: add half, then floor shift
	function automatic longint round_shift(input longint v, input int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic void joint_trig(input angle_t a, output longint c, output longint s);
		longint x, x2, t;
		bit flip;
		x = longint'(a) * (64'sd1 <<< (30 - ANGLE_FRAC_BITS));
		flip = 1'b0;
		while (x > PI_Q30) x -= TWO_PI_Q30;
		while (x < -PI_Q30) x += TWO_PI_Q30;
		// fold into [-pi/2, pi/2]; cosine changes sign
		if (x > HALF_PI_Q30) begin
			x = PI_Q30 - x;
			flip = 1'b1;
		end else if (x < -HALF_PI_Q30) begin
			x = -PI_Q30 - x;
			flip = 1'b1;
		end
		x2 = round_shift(x * x, 30);
		t = 64'sd1 <<< 30;
		for (int i = 0; i < SIN_STEPS; i++)
			t = (64'sd1 <<< 30) - round_shift(t * x2, 30) / SIN_DIV[i];
		s = round_shift(x * t, 30);
		t = 64'sd1 <<< 30;
		for (int i = 0; i < COS_STEPS; i++)
			t = (64'sd1 <<< 30) - round_shift(t * x2, 30) / COS_DIV[i];
		c = flip ? -t : t;
	endfunction

	// Apply one Craig-form link to the running frame
	function automatic void chain_link(input longint ct, input longint st, input int sa,
			input longint a, input longint d);
		longint ca, acc;
		longint ra [3][3];
		longint pa [3];
		longint nr [3][3];
		ca = (sa == 0) ? 1 : 0;
		ra[0][0] = ct;      ra[0][1] = -st;     ra[0][2] = 0;
		ra[1][0] = st * ca; ra[1][1] = ct * ca; ra[1][2] = -longint'(sa) * (64'sd1 <<< 30);
		ra[2][0] = st * sa; ra[2][1] = ct * sa; ra[2][2] = ca * (64'sd1 <<< 30);
		pa[0] = a; pa[1] = -longint'(sa) * d; pa[2] = ca * d;
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int k = 0; k < 3; k++) acc += arm_rot[i][k] * pa[k];
			arm_pos[i] += round_shift(acc, 30 - POS_GUARD);
			for (int j = 0; j < 3; j++) begin
				acc = 0;
				for (int k = 0; k < 3; k++) acc += arm_rot[i][k] * ra[k][j];
				nr[i][j] = round_shift(acc, 30);
			end
		end
		arm_rot = nr;
	endfunction

	function automatic pose_t tip_pose(input joints_t q);
		longint c [NUM_JOINTS];
		longint s [NUM_JOINTS];
		longint one, r;
		pose_t p;
		one = 64'sd1 <<< 30;
		for (int i = 0; i < NUM_JOINTS; i++) joint_trig(q.ang[i], c[i], s[i]);
		for (int i = 0; i < 3; i++) begin
			arm_pos[i] = 0;
			for (int j = 0; j < 3; j++) arm_rot[i][j] = (i == j) ? one : 0;
		end
		chain_link(c[0], s[0], 0, 0, link_len[CFG_BASE_HEIGHT]);
		chain_link(s[1], -c[1], -1, 0, link_len[CFG_SHOULDER_OFFSET]);
		chain_link(c[2], s[2], 0, link_len[CFG_UPPER_ARM], D3_LEN);
		chain_link(c[3], s[3], 0, link_len[CFG_FOREARM], D4_LEN);
		chain_link(0, one, 0, link_len[CFG_WRIST_ONE], D5_LEN);
		chain_link(c[4], s[4], 1, 0, 0);
		chain_link(0, -one, -1, 0, 0);
		chain_link(c[5], s[5], 0, link_len[CFG_WRIST_TWO], link_len[CFG_WRIST_OFFSET]);
		chain_link(one, 0, 0, 0, link_len[CFG_TOOL_OFFSET]);
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				r = round_shift(arm_rot[i][j], 30 - ROT_FRAC_BITS);
				if (r > (64'sd1 <<< ROT_FRAC_BITS)) r = 64'sd1 <<< ROT_FRAC_BITS;
				if (r < -(64'sd1 <<< ROT_FRAC_BITS)) r = -(64'sd1 <<< ROT_FRAC_BITS);
				p.rot[i*3+j] = rot_t'(r);
			end
			r = round_shift(arm_pos[i], POS_GUARD);
			if (r > 524287) r = 524287;
			if (r < -524288) r = -524288;
			p.pos[i] = pos_t'(r);
		end
		return p;
	endfunction

	// Drive joint beats from the pending queue; predict on acceptance
	always @(posedge clk or negedge arst_n) begin
		joints_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				nxt.ang = '{joint_angle_1, joint_angle_2, joint_angle_3,
					joint_angle_4, joint_angle_5, joint_angle_6};
				pose_queue.push_back(tip_pose(nxt));
			end
			if (!in_valid || in_ready) begin
				if (joint_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = joint_queue.pop_front();
					joint_angle_1 <= nxt.ang[0];
					joint_angle_2 <= nxt.ang[1];
					joint_angle_3 <= nxt.ang[2];
					joint_angle_4 <= nxt.ang[3];
					joint_angle_5 <= nxt.ang[4];
					joint_angle_6 <= nxt.ang[5];
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Check pose beats against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		pose_t exp_pose;
		rot_t got_rot [9];
		pos_t got_pos [3];
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got_rot = '{rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
					rot_20, rot_21, rot_22};
				got_pos = '{pos_x, pos_y, pos_z};
				poses_seen++;
				if (pose_queue.size() == 0) begin
					$display("%0t: pose beat with no prediction pending", $time);
					errors++;
				end else begin
					exp_pose = pose_queue.pop_front();
					for (int i = 0; i < 9; i++)
						if (got_rot[i] !== exp_pose.rot[i]) begin
							$display("%0t: rot[%0d] expected %0d actual %0d", $time, i,
								exp_pose.rot[i], got_rot[i]);
							errors++;
						end
					for (int i = 0; i < 3; i++)
						if (got_pos[i] !== exp_pose.pos[i]) begin
							$display("%0t: pos[%0d] expected %0d actual %0d", $time, i,
								exp_pose.pos[i], got_pos[i]);
							errors++;
						end
				end
			end
			// hold off once for a long stretch so the pipeline backs up
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				out_ready <= 1'b0;
			end else if (!hold_done && poses_seen == 150) begin
				hold_done <= 1'b1;
				hold_cycles <= 300;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic write_len(input cfg_reg_t idx, input longint val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 18'(val);
		link_len[idx] = longint'(len_t'(val));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all_lens(input longint val);
		for (int i = 0; i < 8; i++) write_len(cfg_reg_t'(i), val);
	endtask

	task automatic push_joints(input angle_t a0, a1, a2, a3, a4, a5);
		joints_t q;
		q.ang = '{a0, a1, a2, a3, a4, a5};
		joint_queue.push_back(q);
	endtask

	task automatic push_all(input angle_t a);
		push_joints(a, a, a, a, a, a);
	endtask

	// Mostly full-range angles, some near multiples of 90 degrees
	function automatic angle_t rand_angle();
		int k;
		if ($urandom_range(3) == 0) begin
			k = $urandom_range(4);
			return angle_t'((k - 2) * 12868 + int'($urandom_range(6)) - 3);
		end
		return angle_t'($urandom);
	endfunction

	task automatic push_random(input int n);
		repeat (n) push_joints(rand_angle(), rand_angle(), rand_angle(),
			rand_angle(), rand_angle(), rand_angle());
	endtask

	task automatic wait_drained();
		while (joint_queue.size() > 0 || in_valid || pose_queue.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		link_len = '{RST_BASE_HEIGHT, RST_SHOULDER_OFFSET, RST_WRIST_OFFSET,
			RST_TOOL_OFFSET, RST_UPPER_ARM, RST_FOREARM, RST_WRIST_ONE, RST_WRIST_TWO};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, right angles, half turns, single joints
		push_all(16'sd0);
		push_all(16'sd32767);
		push_all(-16'sd32768);
		push_all(16'sd12868);
		push_all(-16'sd12868);
		push_all(16'sd25736);
		push_all(-16'sd25736);
		push_all(16'sd12867);
		push_all(16'sd1);
		push_all(-16'sd1);
		push_joints(16'sd32767, -16'sd32768, 16'sd0, 16'sd12868, -16'sd25736, 16'sd6434);
		for (int j = 0; j < NUM_JOINTS; j++) begin
			joints_t q;
			q.ang = '{default: 16'sd0};
			q.ang[j] = 16'sd12868;
			joint_queue.push_back(q);
		end
		push_random(300);
		wait_drained();

		// largest link lengths; idling swapped
		send_idle_pct = 78;
		recv_idle_pct = 15;
		write_all_lens(131071);
		push_all(16'sd0);
		push_all(16'sd32767);
		push_random(300);
		wait_drained();

		// most negative link lengths; no idling
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_all_lens(-131072);
		push_all(16'sd0);
		push_all(-16'sd32768);
		push_random(300);
		wait_drained();

		// random link lengths, still no idling
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < 8; i++) write_len(cfg_reg_t'(i), longint'(len_t'($urandom)));
		push_random(300);
		wait_drained();

		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
